>>> src/semq_pkg.sv
// Shared types, codes and constants for the semaphore unit.
// No dependencies; used by every module of the unit.
package semq_pkg;

  // default sizes
  localparam int NUM_RESOURCES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int HOLDER_DEPTH_DEF  = 16;

  // fixed field widths
  localparam int NUM_REGS  = 4;
  localparam int CNT_W     = 5;
  localparam int ID_W      = 16;
  localparam int RES_W     = 3;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd1;

  // request actions
  localparam logic [ACT_W-1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WAKE    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ASSIGNED = 4'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED   = 4'd1;
  localparam logic [STAT_W-1:0] ST_RELEASED = 4'd2;
  localparam logic [STAT_W-1:0] ST_INVALID  = 4'd3;
  localparam logic [STAT_W-1:0] ST_NONE     = 4'd4;
  localparam logic [STAT_W-1:0] ST_WOKEN    = 4'd5;
  localparam logic [STAT_W-1:0] ST_REQUEUED = 4'd6;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 4'd7;
  localparam logic [STAT_W-1:0] ST_FULL     = 4'd8;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ACQ,
    OP_REL,
    OP_WAKE,
    OP_REM,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [RES_W-1:0] res;
    logic [ID_W-1:0]  pid;
  } req_t;

endpackage

>>> src/semq_front.sv
// Front end: takes requests and classifies them into operations.
// Depends on semq_pkg.
module semq_front #(
  parameter int NUM_RESOURCES = semq_pkg::NUM_RESOURCES_DEF
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [semq_pkg::ACT_W-1:0]  in_action,
  input  logic [semq_pkg::RES_W-1:0]  in_resource_id,
  input  logic [semq_pkg::ID_W-1:0]   in_proc_id,
  input  logic                        q_full,
  output logic                        q_push,
  output semq_pkg::req_t              q_data
);

  // accept while the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // decode action, flag out of range resources
  always_comb begin
    q_data.res = in_resource_id;
    q_data.pid = in_proc_id;
    case (in_action)
      semq_pkg::ACT_ACQUIRE: q_data.op = semq_pkg::OP_ACQ;
      semq_pkg::ACT_RELEASE: q_data.op = semq_pkg::OP_REL;
      semq_pkg::ACT_WAKE:    q_data.op = semq_pkg::OP_WAKE;
      semq_pkg::ACT_REMOVE:  q_data.op = semq_pkg::OP_REM;
      default:               q_data.op = semq_pkg::OP_BAD;
    endcase
    if (32'(in_resource_id) >= NUM_RESOURCES) begin
      q_data.op = semq_pkg::OP_BAD;
    end
  end

endmodule

>>> src/semq_fifo.sv
// Two-entry request queue between front and back ends.
// Depends on semq_pkg.
module semq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  semq_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output semq_pkg::req_t pop_data,
  output logic           vld
);

  semq_pkg::req_t mem_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign vld      = (cnt_r != 2'd0);
  assign pop_data = mem_r[rptr_r];

  // pointer and fill update
  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> src/semq_back.sv
// Back end: executes operations on counts, wait queues and holder lists.
// Holds both id memories and the output register. Depends on semq_pkg.
module semq_back #(
  parameter int NUM_RESOURCES = semq_pkg::NUM_RESOURCES_DEF,
  parameter int QUEUE_DEPTH   = semq_pkg::QUEUE_DEPTH_DEF,
  parameter int HOLDER_DEPTH  = semq_pkg::HOLDER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_vld,
  input  semq_pkg::req_t                  req,
  output logic                            req_pop,
  output logic                            idle,
  input  logic                            cfg_valid,
  input  logic [semq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [semq_pkg::CNT_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [semq_pkg::STAT_W-1:0]     out_status,
  output logic [semq_pkg::ID_W-1:0]       out_proc_id
);

  localparam int NR   = NUM_RESOURCES;
  localparam int QD   = QUEUE_DEPTH;
  localparam int HD   = HOLDER_DEPTH;
  localparam int RW   = (NR > 1) ? $clog2(NR) : 1;
  localparam int QW   = $clog2(QD);
  localparam int LW   = $clog2(QD + 1);
  localparam int HW   = (HD > 1) ? $clog2(HD) : 1;
  localparam int MXD  = (QD > HD) ? QD : HD;
  localparam int IW   = $clog2(MXD + 2);
  localparam int QAW  = $clog2(NR * QD);
  localparam int HAW  = (NR * HD > 1) ? $clog2(NR * HD) : 1;
  localparam int CW   = semq_pkg::CNT_W;
  localparam int IDW  = semq_pkg::ID_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_HRD, S_HCMP, S_WK, S_QRD, S_QCMP, S_SHRD, S_SHWR, S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  semq_pkg::req_t               cur_r, cur_nxt;
  logic [IW-1:0]                i_r, i_nxt;
  logic [semq_pkg::STAT_W-1:0]  st_r, st_nxt;
  logic [IDW-1:0]               oid_r, oid_nxt;
  logic                         ov_r, ov_nxt;
  logic [semq_pkg::STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [IDW-1:0]               oout_r, oout_nxt;

  logic [CW-1:0]  cnt_r  [NR];
  logic [CW-1:0]  cnt_nxt[NR];
  logic [LW-1:0]  len_r  [NR];
  logic [LW-1:0]  len_nxt[NR];
  logic [QW-1:0]  head_r  [NR];
  logic [QW-1:0]  head_nxt[NR];
  logic [HD-1:0]  hval_r  [NR];
  logic [HD-1:0]  hval_nxt[NR];

  // id memories with registered read
  logic [IDW-1:0] qmem [NR*QD];
  logic [IDW-1:0] hmem [NR*HD];
  logic [IDW-1:0] q_rd_r, h_rd_r;
  logic           q_we, h_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [IDW-1:0] q_wdata, h_wdata;

  logic [RW-1:0]  rr;
  logic [CW-1:0]  cnt_cur;
  logic [LW-1:0]  len_cur;
  logic [QW-1:0]  head_cur;
  logic [QW-1:0]  tail;
  logic           free_any;
  logic [HW-1:0]  free_slot;

  // circular queue position, head below the depth, offset at most the depth
  function automatic logic [QW-1:0] wrap(input logic [QW-1:0] h, input logic [IW-1:0] off);
    logic [IW:0] s;
    s = (IW+1)'(h) + (IW+1)'(off);
    if (s >= (IW+1)'(QD)) begin
      s = s - (IW+1)'(QD);
    end
    return QW'(s);
  endfunction

  function automatic logic [QAW-1:0] qaddr(input logic [RW-1:0] r, input logic [QW-1:0] p);
    return QAW'(QAW'(r) * QAW'(QD) + QAW'(p));
  endfunction

  function automatic logic [HAW-1:0] haddr(input logic [RW-1:0] r, input logic [HW-1:0] p);
    return HAW'(HAW'(r) * HAW'(HD) + HAW'(p));
  endfunction

  assign rr       = cur_r.res[RW-1:0];
  assign cnt_cur  = cnt_r[rr];
  assign len_cur  = len_r[rr];
  assign head_cur = head_r[rr];
  assign tail     = wrap(head_cur, IW'(len_cur));

  assign idle        = (state_r == S_IDLE);
  assign out_valid   = ov_r;
  assign out_status  = ostat_r;
  assign out_proc_id = oout_r;

  // lowest free holder slot
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int k = HD - 1; k >= 0; k--) begin
      if (!hval_r[rr][k]) begin
        free_any  = 1'b1;
        free_slot = HW'(k);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    i_nxt     = i_r;
    st_nxt    = st_r;
    oid_nxt   = oid_r;
    ov_nxt    = ov_r;
    ostat_nxt = ostat_r;
    oout_nxt  = oout_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    head_nxt  = head_r;
    hval_nxt  = hval_r;
    req_pop   = 1'b0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    q_raddr   = '0;
    h_we      = 1'b0;
    h_waddr   = '0;
    h_wdata   = '0;
    h_raddr   = '0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (req_vld) begin
          req_pop   = 1'b1;
          cur_nxt   = req;
          i_nxt     = '0;
          oid_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (cur_r.op)
          semq_pkg::OP_ACQ: begin
            if (cnt_cur == '0) begin
              if (len_cur == LW'(QD)) begin
                st_nxt = semq_pkg::ST_FULL;
              end else begin
                q_we        = 1'b1;
                q_waddr     = qaddr(rr, tail);
                q_wdata     = cur_r.pid;
                len_nxt[rr] = LW'(len_cur + 1'b1);
                st_nxt      = semq_pkg::ST_QUEUED;
              end
            end else if (!free_any) begin
              st_nxt = semq_pkg::ST_FULL;
            end else begin
              h_we                    = 1'b1;
              h_waddr                 = haddr(rr, free_slot);
              h_wdata                 = cur_r.pid;
              hval_nxt[rr][free_slot] = 1'b1;
              cnt_nxt[rr]             = cnt_cur - 1'b1;
              st_nxt                  = semq_pkg::ST_ASSIGNED;
            end
          end
          semq_pkg::OP_REL: begin
            state_nxt = S_HRD;
          end
          semq_pkg::OP_WAKE: begin
            if (len_cur == '0) begin
              st_nxt = semq_pkg::ST_NONE;
            end else begin
              q_raddr   = qaddr(rr, head_cur);
              state_nxt = S_WK;
            end
          end
          semq_pkg::OP_REM: begin
            if (len_cur == '0) begin
              st_nxt = semq_pkg::ST_INVALID;
            end else begin
              state_nxt = S_QRD;
            end
          end
          default: begin
            st_nxt = semq_pkg::ST_INVALID;
          end
        endcase
      end
      // holder scan: read then compare
      S_HRD: begin
        h_raddr   = haddr(rr, i_r[HW-1:0]);
        state_nxt = S_HCMP;
      end
      S_HCMP: begin
        if (hval_r[rr][i_r[HW-1:0]] && h_rd_r == cur_r.pid) begin
          hval_nxt[rr][i_r[HW-1:0]] = 1'b0;
          if (cnt_cur != semq_pkg::COUNT_MAX) begin
            cnt_nxt[rr] = cnt_cur + 1'b1;
          end
          st_nxt    = semq_pkg::ST_RELEASED;
          state_nxt = S_DONE;
        end else if (i_r == IW'(HD - 1)) begin
          st_nxt    = semq_pkg::ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_HRD;
        end
      end
      // head of queue is in the read register
      S_WK: begin
        oid_nxt   = q_rd_r;
        state_nxt = S_DONE;
        if (cnt_cur == '0) begin
          q_we         = 1'b1;
          q_waddr      = qaddr(rr, tail);
          q_wdata      = q_rd_r;
          head_nxt[rr] = wrap(head_cur, IW'(1));
          st_nxt       = semq_pkg::ST_REQUEUED;
        end else if (!free_any) begin
          st_nxt = semq_pkg::ST_FULL;
        end else begin
          head_nxt[rr]            = wrap(head_cur, IW'(1));
          len_nxt[rr]             = LW'(len_cur - 1'b1);
          h_we                    = 1'b1;
          h_waddr                 = haddr(rr, free_slot);
          h_wdata                 = q_rd_r;
          hval_nxt[rr][free_slot] = 1'b1;
          cnt_nxt[rr]             = cnt_cur - 1'b1;
          st_nxt                  = semq_pkg::ST_WOKEN;
        end
      end
      // queue scan for remove
      S_QRD: begin
        q_raddr   = qaddr(rr, wrap(head_cur, i_r));
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        if (q_rd_r == cur_r.pid) begin
          oid_nxt = cur_r.pid;
          st_nxt  = semq_pkg::ST_REMOVED;
          if (IW'(i_r + 1'b1) == IW'(len_cur)) begin
            len_nxt[rr] = LW'(len_cur - 1'b1);
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_SHRD;
          end
        end else if (IW'(i_r + 1'b1) == IW'(len_cur)) begin
          st_nxt    = semq_pkg::ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_QRD;
        end
      end
      // close the gap one entry at a time
      S_SHRD: begin
        q_raddr   = qaddr(rr, wrap(head_cur, IW'(i_r + 1'b1)));
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        q_we    = 1'b1;
        q_waddr = qaddr(rr, wrap(head_cur, i_r));
        q_wdata = q_rd_r;
        if (IW'(i_r + IW'(2)) == IW'(len_cur)) begin
          len_nxt[rr] = LW'(len_cur - 1'b1);
          state_nxt   = S_DONE;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_SHRD;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ostat_nxt = st_r;
          oout_nxt  = oid_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // count load from the register port
    if (cfg_valid && 32'(cfg_index) < semq_pkg::NUM_REGS && 32'(cfg_index) < NR) begin
      cnt_nxt[cfg_index[RW-1:0]] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      for (int k = 0; k < NR; k++) begin
        cnt_r[k]  <= semq_pkg::COUNT_RESET;
        len_r[k]  <= '0;
        head_r[k] <= '0;
        hval_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      head_r  <= head_nxt;
      hval_r  <= hval_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    i_r     <= i_nxt;
    st_r    <= st_nxt;
    oid_r   <= oid_nxt;
    ostat_r <= ostat_nxt;
    oout_r  <= oout_nxt;
  end

  // wait queue id memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rd_r <= qmem[q_raddr];
  end

  // holder id memory
  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    h_rd_r <= hmem[h_raddr];
  end

endmodule

>>> src/counting_semaphore_wait_queues_unit.sv
// Channel   Direction  Signals
// in_       request    in_valid/in_ready, in_action, in_resource_id, in_proc_id
// out_      result     out_valid/out_ready, out_status, out_proc_id
// cfg_      write      cfg_valid/cfg_ready, cfg_index, cfg_data
//
// Release scans the holder slots one at a time until it finds the id; remove
// scans the queue entries the same way and then moves each later entry up. The
// scans read the id memories entry by entry; a stalled result holds the back end.
// Reset is synchronous and needs no clearing pass; counts load to 1.
// A two-entry request queue lets the front accept while a result is stalled.
// Depends on semq_pkg, semq_front, semq_fifo and semq_back.
module counting_semaphore_wait_queues_unit #(
  parameter int NUM_RESOURCES = semq_pkg::NUM_RESOURCES_DEF,
  parameter int QUEUE_DEPTH   = semq_pkg::QUEUE_DEPTH_DEF,
  parameter int HOLDER_DEPTH  = semq_pkg::HOLDER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [semq_pkg::ACT_W-1:0]      in_action,
  input  logic [semq_pkg::RES_W-1:0]      in_resource_id,
  input  logic [semq_pkg::ID_W-1:0]       in_proc_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [semq_pkg::STAT_W-1:0]     out_status,
  output logic [semq_pkg::ID_W-1:0]       out_proc_id,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [semq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [semq_pkg::CNT_W-1:0]      cfg_data
);

  semq_pkg::req_t push_data, pop_data;
  logic           push, pop, full, fvld, bk_idle;

  assign cfg_ready = 1'b1;

  semq_front #(.NUM_RESOURCES(NUM_RESOURCES)) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_resource_id (in_resource_id),
    .in_proc_id     (in_proc_id),
    .q_full         (full),
    .q_push         (push),
    .q_data         (push_data)
  );

  semq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .vld       (fvld)
  );

  semq_back #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HOLDER_DEPTH  (HOLDER_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_vld     (fvld),
    .req         (pop_data),
    .req_pop     (pop),
    .idle        (bk_idle),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_proc_id (out_proc_id)
  );

  // back end only takes a request that is there, and only when idle
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (fvld && bk_idle))
    else $error("request popped from empty queue or busy back end");

  // an accepted request is held in the queue on the next cycle
  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> fvld)
    else $error("accepted request lost");

  // only defined status codes leave the unit
  a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= semq_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

>>> tb/tb_counting_semaphore_wait_queues_unit.sv
// Self-checking testbench for the counting semaphore unit with wait queues.
// Needs semq_pkg and counting_semaphore_wait_queues_unit; stands alone otherwise.
module tb_counting_semaphore_wait_queues_unit;

  localparam int NRES       = semq_pkg::NUM_RESOURCES_DEF;
  localparam int QDEPTH     = semq_pkg::QUEUE_DEPTH_DEF;
  localparam int HDEPTH     = semq_pkg::HOLDER_DEPTH_DEF;
  localparam int ACT_W      = semq_pkg::ACT_W;
  localparam int RES_W      = semq_pkg::RES_W;
  localparam int ID_W       = semq_pkg::ID_W;
  localparam int STAT_W     = semq_pkg::STAT_W;
  localparam int CFG_IDX_W  = semq_pkg::CFG_IDX_W;
  localparam int CNT_W      = semq_pkg::CNT_W;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 300;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_REQS = 75;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [ACT_W-1:0]     in_action;
  logic [RES_W-1:0]     in_resource_id;
  logic [ID_W-1:0]      in_proc_id;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    out_status;
  logic [ID_W-1:0]      out_proc_id;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  counting_semaphore_wait_queues_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_resource_id(in_resource_id), .in_proc_id(in_proc_id),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_proc_id(out_proc_id),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   pid;
  } outcome_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [RES_W-1:0]  res;
    logic [ID_W-1:0]   pid;
    bit                typed;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_pid;
  } dir_row_t;

  // shadow of the unit's semaphore state
  logic [CNT_W-1:0] free_cnt [NRES];
  logic [ID_W-1:0]  waitq    [NRES][QDEPTH];
  int               waitq_len[NRES];
  logic [ID_W-1:0]  holder   [NRES][HDEPTH];
  bit               held     [NRES][HDEPTH];

  outcome_t pending_results[$];
  dir_row_t dir_tab[$];
  int       errors;
  int       idle_cycles;
  int       status_seen[16];
  int       reqs_sent;
  int       cfg_writes;
  bit       hold_req;
  logic [ID_W-1:0] pid_pool[6];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want,
             status_seen.sum());
    errors++;
  endtask

  // remove queue entry at pos, later entries move up
  task automatic waitq_drop(input int r, input int pos);
    for (int i = pos; i + 1 < waitq_len[r]; i++) waitq[r][i] = waitq[r][i+1];
    waitq_len[r]--;
  endtask

  function automatic int free_slot(input int r);
    for (int i = 0; i < HDEPTH; i++) if (!held[r][i]) return i;
    return HDEPTH;
  endfunction

  // expected outcome of one request, updating the shadow state
  task automatic semaphore_outcome(input logic [ACT_W-1:0] act,
                                   input logic [RES_W-1:0] res,
                                   input logic [ID_W-1:0] pid,
                                   output outcome_t o);
    int r;
    int slot;
    r = res;
    o.status = semq_pkg::ST_INVALID;
    o.pid = '0;
    if (r < NRES) begin
      case (act)
        semq_pkg::ACT_ACQUIRE: begin
          if (free_cnt[r] == 0) begin
            if (waitq_len[r] >= QDEPTH) o.status = semq_pkg::ST_FULL;
            else begin
              waitq[r][waitq_len[r]] = pid;
              waitq_len[r]++;
              o.status = semq_pkg::ST_QUEUED;
            end
          end else begin
            slot = free_slot(r);
            if (slot >= HDEPTH) o.status = semq_pkg::ST_FULL;
            else begin
              held[r][slot] = 1'b1;
              holder[r][slot] = pid;
              free_cnt[r]--;
              o.status = semq_pkg::ST_ASSIGNED;
            end
          end
        end
        semq_pkg::ACT_RELEASE: begin
          for (int i = 0; i < HDEPTH; i++) begin
            if (held[r][i] && holder[r][i] == pid) begin
              held[r][i] = 1'b0;
              if (free_cnt[r] != semq_pkg::COUNT_MAX) free_cnt[r]++;
              o.status = semq_pkg::ST_RELEASED;
              break;
            end
          end
        end
        semq_pkg::ACT_WAKE: begin
          if (waitq_len[r] == 0) o.status = semq_pkg::ST_NONE;
          else begin
            o.pid = waitq[r][0];
            if (free_cnt[r] == 0) begin
              // no instance: head goes to the tail
              waitq_drop(r, 0);
              waitq[r][waitq_len[r]] = o.pid;
              waitq_len[r]++;
              o.status = semq_pkg::ST_REQUEUED;
            end else begin
              slot = free_slot(r);
              if (slot >= HDEPTH) o.status = semq_pkg::ST_FULL;
              else begin
                waitq_drop(r, 0);
                held[r][slot] = 1'b1;
                holder[r][slot] = o.pid;
                free_cnt[r]--;
                o.status = semq_pkg::ST_WOKEN;
              end
            end
          end
        end
        default: begin
          for (int i = 0; i < waitq_len[r]; i++) begin
            if (waitq[r][i] == pid) begin
              waitq_drop(r, i);
              o.pid = pid;
              o.status = semq_pkg::ST_REMOVED;
              break;
            end
          end
        end
      endcase
    end
  endtask

  // offer one request and wait for it to be taken
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [RES_W-1:0] res,
                          input logic [ID_W-1:0] pid, input bit typed,
                          input outcome_t typed_out);
    outcome_t o;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_action      <= act;
    in_resource_id <= res;
    in_proc_id     <= pid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    semaphore_outcome(act, res, pid, o);
    pending_results.push_back(typed ? typed_out : o);
    reqs_sent++;
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // register write, only once the unit has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    idle_in(1);
    wait (pending_results.size() == 0);
    repeat (80) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < semq_pkg::NUM_REGS) free_cnt[idx] = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [ACT_W-1:0] act, input logic [RES_W-1:0] res,
                         input logic [ID_W-1:0] pid, input bit typed,
                         input logic [STAT_W-1:0] st, input logic [ID_W-1:0] opid);
    dir_row_t d;
    d.act = act; d.res = res; d.pid = pid; d.typed = typed;
    d.status = st; d.out_pid = opid;
    dir_tab.push_back(d);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 5'd0;
      1: return 5'd16;
      2: return semq_pkg::COUNT_MAX;
      3: return 5'd1;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && out_ready) begin
      status_seen[out_status]++;
      if (pending_results.size() == 0) report("unexpected result, status", out_status, -1);
      else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_proc_id !== e.pid) report("out_proc_id", out_proc_id, e.pid);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // result side stalls: a randomly picked ready pattern, long hold on demand
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= (cyc % 4 != 3);
          2: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        cyc++;
      end
    end
  end

  initial begin
    outcome_t t;
    dir_row_t d;
    int burst;
    logic [ACT_W-1:0] act;
    logic [RES_W-1:0] res;
    logic [ID_W-1:0] pid;

    rst_n = 1'b0;
    in_valid = 1'b0; in_action = semq_pkg::ACT_ACQUIRE; in_resource_id = '0;
    in_proc_id = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_req = 1'b0;
    errors = 0; idle_cycles = 0; reqs_sent = 0; cfg_writes = 0;
    for (int r = 0; r < NRES; r++) begin
      free_cnt[r] = semq_pkg::COUNT_RESET;
      waitq_len[r] = 0;
      for (int i = 0; i < HDEPTH; i++) held[r][i] = 1'b0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed table, every count at 1 after reset
    add_row(semq_pkg::ACT_ACQUIRE, 3'd0, 16'hFFFF, 1, semq_pkg::ST_ASSIGNED, 16'h0);
    add_row(semq_pkg::ACT_ACQUIRE, 3'd0, 16'h0000, 1, semq_pkg::ST_QUEUED,   16'h0);
    add_row(semq_pkg::ACT_ACQUIRE, 3'd0, 16'h0000, 1, semq_pkg::ST_QUEUED,   16'h0);
    add_row(semq_pkg::ACT_ACQUIRE, 3'd5, 16'h0007, 1, semq_pkg::ST_INVALID,  16'h0);
    add_row(semq_pkg::ACT_WAKE,    3'd7, 16'h0000, 1, semq_pkg::ST_INVALID,  16'h0);
    add_row(semq_pkg::ACT_RELEASE, 3'd7, 16'hFFFF, 1, semq_pkg::ST_INVALID,  16'h0);
    add_row(semq_pkg::ACT_REMOVE,  3'd4, 16'h0000, 1, semq_pkg::ST_INVALID,  16'h0);
    add_row(semq_pkg::ACT_WAKE,    3'd1, 16'h0000, 1, semq_pkg::ST_NONE,     16'h0);
    add_row(semq_pkg::ACT_REMOVE,  3'd1, 16'h1234, 1, semq_pkg::ST_INVALID,  16'h0);
    add_row(semq_pkg::ACT_RELEASE, 3'd0, 16'h0001, 1, semq_pkg::ST_INVALID,  16'h0);
    add_row(semq_pkg::ACT_WAKE,    3'd0, 16'h0000, 1, semq_pkg::ST_REQUEUED, 16'h0);
    add_row(semq_pkg::ACT_REMOVE,  3'd0, 16'h0000, 1, semq_pkg::ST_REMOVED,  16'h0);
    add_row(semq_pkg::ACT_RELEASE, 3'd0, 16'hFFFF, 1, semq_pkg::ST_RELEASED, 16'h0);
    add_row(semq_pkg::ACT_WAKE,    3'd0, 16'hABCD, 1, semq_pkg::ST_WOKEN,    16'h0);
    add_row(semq_pkg::ACT_WAKE,    3'd0, 16'h0000, 1, semq_pkg::ST_NONE,     16'h0);
    add_row(semq_pkg::ACT_ACQUIRE, 3'd2, 16'hA5A5, 1, semq_pkg::ST_ASSIGNED, 16'h0);
    add_row(semq_pkg::ACT_RELEASE, 3'd2, 16'hA5A5, 1, semq_pkg::ST_RELEASED, 16'h0);
    add_row(semq_pkg::ACT_REMOVE,  3'd3, 16'h5A5A, 1, semq_pkg::ST_INVALID,  16'h0);
    add_row(semq_pkg::ACT_ACQUIRE, 3'd3, 16'h8001, 0, semq_pkg::ST_ASSIGNED, 16'h0);
    add_row(semq_pkg::ACT_ACQUIRE, 3'd3, 16'h7FFE, 0, semq_pkg::ST_ASSIGNED, 16'h0);
    add_row(semq_pkg::ACT_ACQUIRE, 3'd3, 16'h7FFE, 0, semq_pkg::ST_ASSIGNED, 16'h0);
    add_row(semq_pkg::ACT_REMOVE,  3'd3, 16'h7FFE, 0, semq_pkg::ST_ASSIGNED, 16'h0);
    add_row(semq_pkg::ACT_WAKE,    3'd3, 16'h0000, 0, semq_pkg::ST_ASSIGNED, 16'h0);
    foreach (dir_tab[k]) begin
      d = dir_tab[k];
      t.status = d.status;
      t.pid = d.out_pid;
      send_req(d.act, d.res, d.pid, d.typed, t);
    end

    // fill resource 1: holder list full, queue full, wake blocked, count saturating
    write_reg(3'd1, semq_pkg::COUNT_MAX);
    repeat (HDEPTH + 1) send_req(semq_pkg::ACT_ACQUIRE, 3'd1, 16'h0042, 0, t);
    write_reg(3'd1, 5'd0);
    repeat (QDEPTH + 1)
      send_req(semq_pkg::ACT_ACQUIRE, 3'd1, 16'($urandom_range(0, 3)), 0, t);
    write_reg(3'd1, 5'd16);
    send_req(semq_pkg::ACT_WAKE, 3'd1, 16'h0, 0, t);
    write_reg(3'd1, semq_pkg::COUNT_MAX);
    send_req(semq_pkg::ACT_RELEASE, 3'd1, 16'h0042, 0, t);
    repeat (3) send_req(semq_pkg::ACT_WAKE, 3'd1, 16'h0, 0, t);
    repeat (QDEPTH)
      send_req(semq_pkg::ACT_REMOVE, 3'd1, 16'($urandom_range(0, 3)), 0, t);
    write_reg(3'd6, 5'd31);

    // random phases, each with its own counts and a small pool of ids
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int g = 0; g < semq_pkg::NUM_REGS; g++) write_reg(CFG_IDX_W'(g), pick_count());
      write_reg(CFG_IDX_W'($urandom_range(4, 7)), 5'($urandom_range(0, 31)));
      foreach (pid_pool[k]) pid_pool[k] = 16'($urandom);
      if (ph == 3) hold_req = 1'b1;
      burst = 0;
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (ph == 6 && n == PHASE_REQS / 2) begin
          idle_in(1);
          wait (pending_results.size() == 0);
        end
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: act = semq_pkg::ACT_ACQUIRE;
          7, 8, 9, 10, 11:     act = semq_pkg::ACT_RELEASE;
          12, 13, 14, 15:      act = semq_pkg::ACT_WAKE;
          default:             act = semq_pkg::ACT_REMOVE;
        endcase
        res = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                          : 3'($urandom_range(0, NRES - 1));
        pid = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                          : pid_pool[$urandom_range(0, 5)];
        send_req(act, res, pid, 0, t);
        // bursts with gaps, none at all in some phases
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          if (ph % 4 != 2) idle_in($urandom_range(0, 8));
        end else burst--;
      end
    end

    // drain, then let the unit settle
    idle_in(1);
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d requests and %0d register writes over %0d phases",
             reqs_sent, cfg_writes, NUM_PHASES);
    $display("results: assigned %0d queued %0d released %0d invalid %0d none %0d",
             status_seen[semq_pkg::ST_ASSIGNED], status_seen[semq_pkg::ST_QUEUED],
             status_seen[semq_pkg::ST_RELEASED], status_seen[semq_pkg::ST_INVALID],
             status_seen[semq_pkg::ST_NONE]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> counting_semaphore_wait_queues_unit.f
src/semq_pkg.sv
src/semq_front.sv
src/semq_fifo.sv
src/semq_back.sv
src/counting_semaphore_wait_queues_unit.sv
tb/tb_counting_semaphore_wait_queues_unit.sv
